[rtl/core/kmp_pkg.sv]
// Shared constants, widths and payload types for the k-transaction profit engine.
// No dependencies; every module of the block imports this package.
package kmp_pkg;

    // Most buy-sell pairs tracked; one cell per completed-sale count.
    localparam int K_MAX      = 32;
    localparam int PRICE_BITS = 16;

    // Configuration register
    localparam int               CFG_W     = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

    // Balance width: price plus growth over K_MAX sales, plus sign and margin
    localparam int BAL_W  = PRICE_BITS + $clog2(K_MAX + 1) + 2;
    // Non-negative part of a balance, as seen by the max tree
    localparam int LEAF_W = BAL_W - 1;

    // Result field
    localparam int                  PROFIT_W   = 21;
    localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

    // Max tree over the idle balances, padded to a power of two
    localparam int TREE_L = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int LEAVES = 1 << TREE_L;

    // Result buffer, deep enough to cover the pipeline at full rate
    localparam int FIFO_D = 1 << ($clog2(TREE_L + 3) + 1);
    localparam int PTR_W  = $clog2(FIFO_D);
    localparam int CNT_W  = $clog2(FIFO_D + 1);

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = ((PROFIT_W + 7) / 8) * 8;

    // Index compare width for the k mask
    localparam int IDX_W = $clog2(K_MAX + 1);
    localparam int CMP_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;

    // One balance with its reachability flag
    typedef struct packed {
        logic                    vld;
        logic signed [BAL_W-1:0] val;
    } bal_t;

    // Control carried alongside a transaction through the tree
    typedef struct packed {
        logic vld;
        logic last;
    } tag_t;

    // One finished result
    typedef struct packed {
        logic                done;
        logic [PROFIT_W-1:0] profit;
    } res_t;

endpackage

[rtl/core/k_transaction_max_profit_dp_top.sv]
// Top level of the k-transaction best-profit engine: cell chain, max tree, result buffer.
// Depends on kmp_pkg, kmp_cell, kmp_max_tree and kmp_out_fifo.
//
// Takes one price per clock and returns one result per price: the best profit so far in
// the current series using at most max_transactions buy-sell pairs (capped at K_MAX).
// A chain of K_MAX cells updates all sale counts in the cycle a price is accepted; each
// cell does two adds and two compares and passes its idle balance to the next cell. The
// maximum over the idle balances then runs through a registered tree of log2(K_MAX)
// levels, and each result is then written into the result buffer.
// Results wait in a FIFO_D-entry buffer; the input keeps taking prices back to back as
// long as fewer than FIFO_D transactions are in flight or waiting at the output.
// tuser = first_of_series restarts all balances with this price; tlast passes through.
module k_transaction_max_profit_dp_top import kmp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,     // max_transactions
    // price stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] price
    input  logic                   s_axis_tuser,  // [0] first_of_series
    input  logic                   s_axis_tlast,  // last_of_series
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [20:0] best_profit, rest zero
    output logic                   m_axis_tlast   // series_done
);

    localparam int SAT_W = (LEAF_W > PROFIT_W) ? LEAF_W : PROFIT_W;

    logic [CFG_W-1:0]      k_cfg_reg;
    logic [CFG_W-1:0]      k_reg;
    tag_t                  tag0_reg;
    tag_t                  tag0_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    logic                  s_acc;
    logic                  m_acc;
    logic [PRICE_BITS-1:0] price;
    bal_t                  idle  [K_MAX];
    bal_t                  left  [K_MAX];
    logic [LEAF_W-1:0]     leaves [LEAVES];
    logic [CMP_W-1:0]      k_cmp;
    logic [LEAF_W-1:0]     root;
    tag_t                  root_tag;
    logic [SAT_W-1:0]      root_x;
    res_t                  res;
    res_t                  fifo_out;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign price = s_axis_tdata[PRICE_BITS-1:0];

    // Hold the transaction limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            k_cfg_reg <= cfg_wdata;
        end
    end

    // Reserve buffer space for every transaction in flight
    assign s_axis_tready = (cnt_reg < CNT_W'(FIFO_D));
    assign cnt_next      = cnt_reg + CNT_W'(s_acc) - CNT_W'(m_acc);

    always_comb
    begin
        tag0_next.vld  = s_acc;
        tag0_next.last = s_axis_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            tag0_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            tag0_reg <= tag0_next;
        end
    end

    // Capture the limit that goes with this price
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            k_reg <= k_cfg_reg;
        end
    end

    // Chain of cells; count zero idle balance is always zero and reachable
    for (genvar m = 0; m < K_MAX; m++)
    begin : g_cell
        if (m == 0)
        begin : g_head
            assign left[m] = '{vld: 1'b1, val: '0};
        end
        else
        begin : g_link
            assign left[m] = '{vld: idle[m-1].vld && !s_axis_tuser, val: idle[m-1].val};
        end

        kmp_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (s_acc),
            .first (s_axis_tuser),
            .price (price),
            .left  (left[m]),
            .idle  (idle[m])
        );
    end

    // Mask idle balances beyond the limit, unreachable or below zero
    assign k_cmp = CMP_W'(k_reg);

    for (genvar m = 0; m < LEAVES; m++)
    begin : g_leaf
        if (m < K_MAX)
        begin : g_used
            assign leaves[m] = (idle[m].vld && !idle[m].val[BAL_W-1] && (CMP_W'(m) < k_cmp))
                             ? idle[m].val[LEAF_W-1:0] : '0;
        end
        else
        begin : g_pad
            assign leaves[m] = '0;
        end
    end

    kmp_max_tree u_tree
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .leaves  (leaves),
        .tag_in  (tag0_reg),
        .root    (root),
        .tag_out (root_tag)
    );

    // Saturate the best profit to the result width
    assign root_x = SAT_W'(root);

    always_comb
    begin
        res.done   = root_tag.last;
        res.profit = (root_x > SAT_W'(PROFIT_MAX)) ? PROFIT_MAX : root_x[PROFIT_W-1:0];
    end

    kmp_out_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (root_tag.vld),
        .wr_data  (res),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (fifo_out)
    );

    assign m_axis_tdata = OUT_TDATA_W'(fifo_out.profit);
    assign m_axis_tlast = fifo_out.done;

endmodule

[rtl/core/kmp_cell.sv]
// One cell of the balance chain: holding and idle balance for one sale count.
// Depends on kmp_pkg; takes the idle balance of the count below from its neighbor.
module kmp_cell import kmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  first,
    input  logic [PRICE_BITS-1:0] price,
    input  bal_t                  left,
    output bal_t                  idle
);

    bal_t hold_reg;
    bal_t hold_next;
    bal_t idle_reg;
    bal_t idle_next;

    logic signed [BAL_W-1:0] p_s;
    logic signed [BAL_W-1:0] buy;
    logic signed [BAL_W-1:0] sell;
    logic                    hold_v;
    logic                    idle_v;

    assign p_s = signed'(BAL_W'(price));

    // Drop own balances at the start of a series
    assign hold_v = hold_reg.vld && !first;
    assign idle_v = idle_reg.vld && !first;

    assign buy  = left.val - p_s;
    assign sell = hold_reg.val + p_s;

    // Keep holding or buy from one count lower
    always_comb
    begin
        hold_next.vld = hold_v;
        hold_next.val = hold_reg.val;
        if (left.vld && (!hold_v || (buy > hold_reg.val)))
        begin
            hold_next.vld = 1'b1;
            hold_next.val = buy;
        end
    end

    // Stay idle or sell the share held at this count
    always_comb
    begin
        idle_next.vld = idle_v;
        idle_next.val = idle_reg.val;
        if (hold_v && (!idle_v || (sell > idle_reg.val)))
        begin
            idle_next.vld = 1'b1;
            idle_next.val = sell;
        end
    end

    // Clear on reset, advance the balances on each accepted price
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
            idle_reg <= '0;
        end
        else if (step)
        begin
            hold_reg <= hold_next;
            idle_reg <= idle_next;
        end
    end

    assign idle = idle_reg;

endmodule

[rtl/core/kmp_max_tree.sv]
// Registered maximum tree over the masked idle balances, with a register at every level.
// Depends on kmp_pkg; a tag travels alongside each level.
module kmp_max_tree import kmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LEAF_W-1:0] leaves [LEAVES],
    input  tag_t              tag_in,
    output logic [LEAF_W-1:0] root,
    output tag_t              tag_out
);

    // Levels stored flat: level l starts at LEAVES - (LEAVES >> (l-1))
    logic [LEAF_W-1:0] node_reg  [LEAVES-1];
    logic [LEAF_W-1:0] node_next [LEAVES-1];
    tag_t              tag_reg   [TREE_L];

    for (genvar l = 1; l <= TREE_L; l++)
    begin : g_lvl
        localparam int N    = LEAVES >> l;
        localparam int OFF  = LEAVES - (LEAVES >> (l - 1));
        localparam int POFF = OFF - 2 * N;
        for (genvar i = 0; i < N; i++)
        begin : g_node
            logic [LEAF_W-1:0] a;
            logic [LEAF_W-1:0] b;
            if (l == 1)
            begin : g_leaf
                assign a = leaves[2*i];
                assign b = leaves[2*i+1];
            end
            else
            begin : g_inner
                assign a = node_reg[POFF+2*i];
                assign b = node_reg[POFF+2*i+1];
            end
            assign node_next[OFF+i] = (a > b) ? a : b;
        end
    end

    // Advance every level each cycle
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    // Shift the tags in step with the levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < TREE_L; l++)
            begin
                tag_reg[l] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int l = 1; l < TREE_L; l++)
            begin
                tag_reg[l] <= tag_reg[l-1];
            end
        end
    end

    assign root    = node_reg[LEAVES-2];
    assign tag_out = tag_reg[TREE_L-1];

endmodule

[rtl/core/kmp_out_fifo.sv]
// Result buffer between the free-running pipeline and the output stream.
// Depends on kmp_pkg; space is reserved upstream, so a write never meets a full buffer.
module kmp_out_fifo import kmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  res_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output res_t rd_data
);

    res_t             mem_reg [FIFO_D];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rd_en;

    assign rd_valid = (count_reg != '0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a finished result
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
